/* rtl/can_seg_pkg.sv */
// can_seg_pkg: item types and constants shared by the entry segmenter modules
// no dependencies; imported by every module of the segmenter
package can_seg_pkg;

	localparam int EXT_FLAG_BIT = 27;
	localparam logic [3:0] HEAD_BYTES = 4'd4;
	localparam logic [3:0] FRAME_BYTES = 4'd8;
	localparam logic [11:0] ID_FIELD_MASK = 12'hfff;

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_BYTE = 1'b1;

	typedef struct packed {
		logic kind;
		logic [2:0] command_code;
		logic [11:0] target_id;
		logic [15:0] entry_index;
		logic [7:0] entry_subindex;
		logic [7:0] entry_length;
		logic [7:0] value_byte;
	} in_item_t;

	typedef struct packed {
		logic [28:0] frame_id;
		logic [3:0] frame_len;
		logic [31:0] data_low;
		logic [31:0] data_high;
		logic last_frame;
	} out_item_t;

	// input register contents as seen by the frame builder
	typedef struct packed {
		logic valid;
		in_item_t item;
	} stage_t;

	// builder result towards the output register
	typedef struct packed {
		logic emit;
		out_item_t frame;
	} build_res_t;

endpackage

/* rtl/can_entry_segmenter.sv */
// can_entry_segmenter: top level of the object-dictionary entry to CAN frame segmenter
// depends on can_seg_pkg, can_seg_in_reg, can_seg_builder, can_seg_out_reg
//
// a header transaction opens an entry (command, target, index, subindex, length),
// then value bytes arrive one per transaction; the first frame carries index,
// subindex, length and up to four bytes, each later frame has the extended flag
// set, a segment number in byte 0 and up to seven bytes; a frame leaves when it is
// full or the entry's last byte arrives, marked last on the final one. bytes with
// no open entry are dropped. one transaction is taken every cycle unless a held
// frame stalls the input: an input register feeds a single pass of frame assembly
// into a result register. device_id is read when a frame is formed and is to be
// written only while the block is idle.
module can_entry_segmenter
	import can_seg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	// configuration: own node id
	input  logic device_id_we,
	input  logic [11:0] device_id,
	// item input
	input  logic in_valid,
	output logic in_stall,
	input  in_item_t in_item,
	// frame output
	output logic out_valid,
	input  logic out_stall,
	output out_item_t out_item
);

	logic [11:0] device_id_q;
	stage_t stage;
	build_res_t res;
	logic out_free;
	logic take;

	// own node id register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= '0;
		end else if (device_id_we) begin
			device_id_q <= device_id;
		end
	end

	// the held item is consumed unless it makes a frame and the result register is full
	assign take = stage.valid && (!res.emit || out_free);

	can_seg_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.take     (take),
		.stage    (stage)
	);

	can_seg_builder u_build (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage     (stage),
		.device_id (device_id_q),
		.take      (take),
		.res       (res)
	);

	can_seg_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && res.emit),
		.frame     (res.frame),
		.free      (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

/* rtl/can_seg_in_reg.sv */
// can_seg_in_reg: input register of the segmenter, one transaction deep
// depends on can_seg_pkg
module can_seg_in_reg
	import can_seg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_item_t in_item,
	input  logic take,
	output stage_t stage
);

	logic valid_s1;
	in_item_t item_s1;
	logic accept;

	assign in_stall = valid_s1 && !take;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.item = item_s1;

endmodule

/* rtl/can_seg_builder.sv */
// can_seg_builder: entry state and frame assembly, one item per cycle while take is high
// depends on can_seg_pkg
module can_seg_builder
	import can_seg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  stage_t stage,
	input  logic [11:0] device_id,
	input  logic take,
	output build_res_t res
);

	logic [2:0] cmd_q;
	logic [11:0] target_q;
	logic [7:0] total_q;
	logic [7:0] taken_q;
	logic [5:0] seg_q;
	logic [63:0] buf_q;
	logic [3:0] fill_q;
	logic open_q;

	logic [2:0] cmd_d;
	logic [11:0] target_d;
	logic [7:0] total_d;
	logic [7:0] taken_d;
	logic [5:0] seg_d;
	logic [63:0] buf_d;
	logic [3:0] fill_d;
	logic open_d;

	logic emit;
	logic ext;
	logic last;
	logic [63:0] frame_buf;
	logic [3:0] frame_fill;
	logic [28:0] frame_id;

	always_comb begin
		logic [63:0] ins;
		logic [3:0] fill_inc;
		logic [7:0] taken_inc;
		cmd_d = cmd_q;
		target_d = target_q;
		total_d = total_q;
		taken_d = taken_q;
		seg_d = seg_q;
		buf_d = buf_q;
		fill_d = fill_q;
		open_d = open_q;
		emit = 1'b0;
		ext = 1'b0;
		last = 1'b0;
		frame_buf = buf_q;
		frame_fill = fill_q;
		ins = buf_q;
		fill_inc = fill_q + 4'd1;
		taken_inc = taken_q + 8'd1;
		for (int i = 0; i < 8; i++) begin
			if (fill_q[2:0] == 3'(i)) begin
				ins[8*i +: 8] = buf_q[8*i +: 8] | stage.item.value_byte;
			end
		end
		if (stage.valid) begin
			if (stage.item.kind == KIND_HEADER) begin
				cmd_d = stage.item.command_code;
				target_d = stage.item.target_id & ID_FIELD_MASK;
				total_d = stage.item.entry_length;
				taken_d = 8'd0;
				seg_d = 6'd0;
				buf_d = {32'd0, stage.item.entry_length, stage.item.entry_subindex,
					stage.item.entry_index[15:8], stage.item.entry_index[7:0]};
				fill_d = HEAD_BYTES;
				frame_buf = buf_d;
				frame_fill = HEAD_BYTES;
				// empty entry goes out as a lone first frame
				if (stage.item.entry_length == 8'd0) begin
					emit = 1'b1;
					last = 1'b1;
					open_d = 1'b0;
				end else begin
					open_d = 1'b1;
				end
			end else if (open_q) begin
				taken_d = taken_inc;
				fill_d = fill_inc;
				buf_d = ins;
				frame_buf = ins;
				frame_fill = fill_inc;
				ext = (seg_q != 6'd0);
				if (taken_inc == total_q) begin
					emit = 1'b1;
					last = 1'b1;
					open_d = 1'b0;
				end else if (fill_inc == FRAME_BYTES) begin
					emit = 1'b1;
					buf_d = {58'd0, seg_q};
					fill_d = 4'd1;
					seg_d = seg_q + 6'd1;
				end
			end
		end
	end

	// header frames take command and target from the item itself, the node id from the register
	always_comb begin
		logic [2:0] c;
		logic [11:0] t;
		c = cmd_d;
		t = target_d;
		frame_id = {2'b00, c, device_id & ID_FIELD_MASK, t};
		if (ext) begin
			frame_id[EXT_FLAG_BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= '0;
			target_q <= '0;
			total_q <= '0;
			taken_q <= '0;
			seg_q <= '0;
			buf_q <= '0;
			fill_q <= '0;
			open_q <= 1'b0;
		end else if (take) begin
			cmd_q <= cmd_d;
			target_q <= target_d;
			total_q <= total_d;
			taken_q <= taken_d;
			seg_q <= seg_d;
			buf_q <= buf_d;
			fill_q <= fill_d;
			open_q <= open_d;
		end
	end

	assign res.emit = emit;
	assign res.frame.frame_id = frame_id;
	assign res.frame.frame_len = frame_fill;
	assign res.frame.data_low = frame_buf[31:0];
	assign res.frame.data_high = frame_buf[63:32];
	assign res.frame.last_frame = last;

endmodule

/* rtl/can_seg_out_reg.sv */
// can_seg_out_reg: result register holding one frame until the sink takes it
// depends on can_seg_pkg
module can_seg_out_reg
	import can_seg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  out_item_t frame,
	output logic free,
	output logic out_valid,
	input  logic out_stall,
	output out_item_t out_item
);

	logic out_valid_q;
	out_item_t out_item_q;

	assign free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q <= frame;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule

/* rtl/can_seg_checker.sv */
// can_seg_checker: port-level checks on the segmenter's frame output
// depends on can_seg_pkg; bound to can_entry_segmenter
module can_seg_checker
	import can_seg_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input out_item_t out_item
);

	// a stalled frame stays offered unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_item)))
		else $error("stalled frame changed");

	// frame length within one to eight
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.frame_len != 4'd0 && out_item.frame_len <= FRAME_BYTES))
		else $error("frame length out of range");

	// only the final frame of an entry may be short
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_item.last_frame) |-> (out_item.frame_len == FRAME_BYTES))
		else $error("non-final frame not full");

	// first frame always holds the four header bytes
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_item.frame_id[EXT_FLAG_BIT]) |-> (out_item.frame_len >= HEAD_BYTES))
		else $error("first frame shorter than header");

endmodule

bind can_entry_segmenter can_seg_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

/* bench/can_entry_segmenter_test.sv */
// can_entry_segmenter_test: self-checking bench for the entry to CAN frame segmenter
// depends on can_seg_pkg and can_entry_segmenter; an internal predictor builds the
// expected frames for every accepted transaction and the monitor checks them in order
module can_entry_segmenter_test;
	import can_seg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// generous ceiling: ~2100 items, each at worst an idle burst, a stall burst and the pipeline
	localparam int CYCLE_LIMIT = 400000;
	// lets the input and result registers empty and catches stray frames
	localparam int SETTLE_CYCLES = 8;
	// the one long receiver hold-off
	localparam int HOLD_OFF_CYCLES = 300;

	logic clk;
	logic arst_n = 1'b0;
	logic device_id_we = 1'b0;
	logic [11:0] device_id = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;

	// stimulus and expectations
	in_item_t items_to_send[$];
	out_item_t frames_due[$];
	int mismatches = 0;

	// idle control, percent chance of starting a burst per opportunity
	int in_idle_pct = 0;
	int out_idle_pct = 0;
	int tx_gap_left;
	int rx_hold_left;
	logic pressure_req = 1'b0;
	logic hold_off = 1'b0;

	// predictor copy of the register and the entry in progress
	logic [11:0] dev_id_model = '0;
	logic [2:0] ent_cmd = '0;
	logic [11:0] ent_target = '0;
	logic [7:0] ent_total = '0;
	logic [7:0] ent_taken = '0;
	logic [5:0] ent_seg = '0;
	logic [63:0] ent_frame = '0;
	logic [3:0] ent_fill = '0;
	logic ent_open = 1'b0;

	can_entry_segmenter uut (
		.clk(clk),
		.arst_n(arst_n),
		.device_id_we(device_id_we),
		.device_id(device_id),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// frame as it would leave now, from the entry being built
	function automatic out_item_t frame_of(logic ext, logic last);
		out_item_t f;
		f.frame_id = {2'b00, ent_cmd, dev_id_model, ent_target};
		if (ext) begin
			f.frame_id[EXT_FLAG_BIT] = 1'b1;
		end
		f.frame_len = ent_fill;
		f.data_low = ent_frame[31:0];
		f.data_high = ent_frame[63:32];
		f.last_frame = last;
		return f;
	endfunction

	// advance the entry state by one accepted transaction, queue any frame it completes
	task automatic segment_item(in_item_t it);
		if (it.kind == KIND_HEADER) begin
			// a header always restarts, an open entry is simply dropped
			ent_cmd = it.command_code;
			ent_target = it.target_id;
			ent_total = it.entry_length;
			ent_taken = '0;
			ent_seg = '0;
			ent_frame = {32'd0, it.entry_length, it.entry_subindex, it.entry_index};
			ent_fill = HEAD_BYTES;
			if (it.entry_length == 8'd0) begin
				// empty entry: first frame goes out straight away
				frames_due.push_back(frame_of(1'b0, 1'b1));
				ent_open = 1'b0;
			end else begin
				ent_open = 1'b1;
			end
		end else if (ent_open) begin
			ent_frame[8 * ent_fill +: 8] = it.value_byte;
			ent_fill = ent_fill + 4'd1;
			ent_taken = ent_taken + 8'd1;
			if (ent_taken == ent_total) begin
				frames_due.push_back(frame_of(ent_seg != 0, 1'b1));
				ent_open = 1'b0;
			end else if (ent_fill == FRAME_BYTES) begin
				frames_due.push_back(frame_of(ent_seg != 0, 1'b0));
				// next segment starts with its number in byte 0
				ent_frame = {58'd0, ent_seg};
				ent_fill = 4'd1;
				ent_seg = ent_seg + 6'd1;
			end
		end
		// bytes with no open entry are dropped by the block
	endtask

	// sender: one transaction offered at a time, payload held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			tx_gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				segment_item(in_item);
			end
			if (!in_valid || !in_stall) begin
				if (tx_gap_left != 0) begin
					tx_gap_left <= tx_gap_left - 1;
					in_valid <= 1'b0;
				end else if (items_to_send.size() != 0 && in_idle_pct != 0
						&& $urandom_range(0, 99) < in_idle_pct) begin
					// start an idle burst; this idle slot counts as part of it
					tx_gap_left <= $urandom_range(0, 13);
					in_valid <= 1'b0;
				end else if (items_to_send.size() != 0) begin
					in_item <= items_to_send.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall bursts plus the long hold-off, and the frame check
	always @(posedge clk or negedge arst_n) begin : frame_monitor
		out_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_hold_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (frames_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected frame: %h", out_item);
					end
				end else begin
					want = frames_due.pop_front();
					if (out_item.frame_id !== want.frame_id
							|| out_item.frame_len !== want.frame_len
							|| out_item.data_low !== want.data_low
							|| out_item.data_high !== want.data_high
							|| out_item.last_frame !== want.last_frame) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display({"frame mismatch: id %h/%h len %0d/%0d",
								" lo %h/%h hi %h/%h last %b/%b"},
								want.frame_id, out_item.frame_id,
								want.frame_len, out_item.frame_len,
								want.data_low, out_item.data_low,
								want.data_high, out_item.data_high,
								want.last_frame, out_item.last_frame);
						end
					end
				end
			end
			if (rx_hold_left != 0) begin
				rx_hold_left <= rx_hold_left - 1;
				out_stall <= 1'b1;
			end else if (hold_off) begin
				out_stall <= 1'b1;
			end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
				rx_hold_left <= $urandom_range(0, 13);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted here while the sender keeps offering
	initial begin
		wait (pressure_req);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// watchdog
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// random item so that fields the block ignores still toggle
	function automatic in_item_t noise_item();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(in_item_t)-1:0];
	endfunction

	task automatic queue_header(logic [2:0] cmd, logic [11:0] target, logic [15:0] idx,
			logic [7:0] sub, logic [7:0] len);
		in_item_t it;
		it = noise_item();
		it.kind = KIND_HEADER;
		it.command_code = cmd;
		it.target_id = target;
		it.entry_index = idx;
		it.entry_subindex = sub;
		it.entry_length = len;
		items_to_send.push_back(it);
	endtask

	task automatic queue_byte(logic [7:0] value);
		in_item_t it;
		it = noise_item();
		it.kind = KIND_BYTE;
		it.value_byte = value;
		items_to_send.push_back(it);
	endtask

	// header with random content, then the first n_bytes of its value bytes
	task automatic queue_entry(int len, int n_bytes);
		queue_header(3'($urandom_range(0, 7)), 12'($urandom_range(0, 4095)),
			16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), 8'(len));
		repeat (n_bytes) queue_byte(8'($urandom_range(0, 255)));
	endtask

	// mostly short entries, the odd long one
	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 0;
		if (r < 65) return $urandom_range(1, 12);
		if (r < 98) return $urandom_range(13, 40);
		return $urandom_range(41, 255);
	endfunction

	// well-formed entries, cut-short entries that a new header abandons, stray bytes
	task automatic queue_random_entries(int n_items);
		int counted, len, cut, r;
		counted = 0;
		while (counted < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				len = pick_length();
				queue_entry(len, len);
				counted += len + 1;
			end else if (r < 92) begin
				len = $urandom_range(2, 40);
				cut = $urandom_range(0, len - 1);
				queue_entry(len, cut);
				counted += cut + 1;
				len = pick_length();
				queue_entry(len, len);
				counted += len + 1;
			end else begin
				// surplus bytes after a finished entry, ignored
				repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// wait until every transaction is in and every frame is out, then let the pipe empty
	task automatic drain();
		while (items_to_send.size() != 0 || in_valid || frames_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register writes only with the block idle
	task automatic set_device_id(logic [11:0] value);
		drain();
		@(posedge clk);
		device_id_we <= 1'b1;
		device_id <= value;
		dev_id_model = value;
		@(posedge clk);
		device_id_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: field extremes and the special cases
		set_device_id(12'hfff);
		queue_byte(8'h5a);                                    // byte with no entry open
		queue_header(3'd7, 12'hfff, 16'hffff, 8'hff, 8'd0);   // empty entry
		queue_header(3'd0, 12'h000, 16'h0000, 8'h00, 8'd4);   // exactly four bytes
		queue_byte(8'hff);
		queue_byte(8'h00);
		queue_byte(8'hff);
		queue_byte(8'ha5);
		queue_header(3'd5, 12'h123, 16'habcd, 8'h01, 8'd5);   // abandoned after two bytes
		queue_byte(8'h11);
		queue_byte(8'h22);
		queue_header(3'd3, 12'h800, 16'h1234, 8'h80, 8'd12);  // first, full segment, short last
		for (int i = 0; i < 12; i++) begin
			queue_byte(8'(8'h30 + i));
		end
		queue_byte(8'h77);                                    // surplus byte
		drain();

		// moderate idling on both sides, device id at its low extreme
		set_device_id(12'h000);
		in_idle_pct = 15;
		out_idle_pct = 15;
		@(negedge clk);
		queue_random_entries(700);
		drain();

		// back-pressure: sender never idles while the receiver holds off
		set_device_id(12'($urandom_range(0, 4095)));
		in_idle_pct = 0;
		out_idle_pct = 0;
		@(negedge clk);
		pressure_req = 1'b1;
		queue_random_entries(300);
		drain();

		// heavy idling
		set_device_id(12'($urandom_range(0, 4095)));
		in_idle_pct = 40;
		out_idle_pct = 40;
		@(negedge clk);
		queue_random_entries(500);
		drain();

		// closing stretch at full rate, one longest entry included
		set_device_id(12'($urandom_range(0, 4095)));
		in_idle_pct = 0;
		out_idle_pct = 0;
		@(negedge clk);
		queue_entry(255, 255);
		queue_random_entries(400);
		drain();

		if (frames_due.size() != 0) begin
			mismatches += frames_due.size();
			$display("frames never seen: %0d", frames_due.size());
		end
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
